### rtl/cbm_pkg.sv
// Shared types, constants and bin mapping for the color histogram bin mean block.
package cbm_pkg;

	localparam int BINS_PER_CHANNEL = 4;
	localparam int CUBE_BINS        = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
	localparam int BIN_W            = 6;
	localparam int CH_BIN_W         = $clog2(BINS_PER_CHANNEL);
	localparam int COUNT_WIDTH_DEF  = 22;
	localparam int COUNT_OUT_W      = 22;
	localparam int RGB_SUM_W        = 30;
	localparam int LAB_SUM_W        = 34;
	localparam int DIV_W            = 32;
	localparam int DVD_W            = 38;
	localparam int QUO_W            = 17;
	localparam int FIFO_DEPTH       = 4;
	localparam int IN_TDATA_W       = 64;
	localparam int OUT_TDATA_W      = 176;

	localparam logic [9:0]             DARK_INIT     = 10'h3FF;
	localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = '1;

	typedef struct packed {
		logic [BIN_W-1:0]  bin;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [10:0]       lab_l;
		logic signed [11:0] lab_a;
		logic signed [11:0] lab_b;
		logic              last;
		logic [23:0]       dark_rgb;
		logic [35:0]       dark_lab;
	} pix_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_UPD,
		BK_EMIT_RD,
		BK_EMIT_LD,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		CMP_RED,
		CMP_GREEN,
		CMP_BLUE,
		CMP_L,
		CMP_A,
		CMP_B
	} comp_t;

	function automatic logic [CH_BIN_W-1:0] chan_bin(input logic [7:0] v);
		int idx;
		idx = 0;
		for (int i = 0; i < BINS_PER_CHANNEL - 1; i++) begin
			if (int'(v) * BINS_PER_CHANNEL > 255 * (i + 1))
				idx = idx + 1;
		end
		return CH_BIN_W'(idx);
	endfunction

	function automatic logic [BIN_W-1:0] cube_bin(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int idx;
		idx = (int'(chan_bin(r)) * BINS_PER_CHANNEL + int'(chan_bin(g))) * BINS_PER_CHANNEL
			+ int'(chan_bin(b));
		return BIN_W'(idx);
	endfunction

endpackage

### rtl/color_histogram_bin_mean_core.sv
// Top level of the RGB cube histogram with per-bin mean colors.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  one pixel per transaction, s_tlast ends the frame
// m_*       out  m_tvalid/m_tready  one bin result per transaction, m_tlast on the final bin
//
// In the accumulator a pixel goes through a store read, then a write back.
// On the final pixel each bin is read, loaded and divided six times by the shared
// bit-serial divider (not for an empty bin); all CUBE_BINS results leave in bin order.
// The intake keeps taking pixels into a FIFO_DEPTH queue while the store works.
// Reset clears the store at once through per-bin valid bits; no clearing sweep.
// m_tready low holds the result register and stops the emission sweep.
module color_histogram_bin_mean_core import cbm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// red[7:0] green[15:8] blue[23:16] lab_l[34:24] lab_a[46:35] lab_b[58:47]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	input  logic                   s_tlast,
	output logic                   s_tready,
	// bin_index[5:0] pixel_count[27:6] mean_red[43:28] mean_green[59:44]
	// mean_blue[75:60] mean_l[86:76] mean_a[98:87] mean_bb[110:99]
	// darkest_rgb[134:111] darkest_lab[170:135]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	output logic                   m_tlast,
	input  logic                   m_tready
);

	logic     push, full, pop, empty;
	pix_t     push_data, head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	cbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.s_tready  (s_tready),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	cbm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	cbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cbm_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tlast  (m_tlast),
		.m_tready (m_tready),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

endmodule

### rtl/cbm_front.sv
// Pixel intake: bin classification and darkest pixel tracking.
module cbm_front import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	output logic                  push,
	output pix_t                  push_data,
	input  logic                  full
);

	logic [9:0]  dark_sum_q;
	logic [23:0] dark_rgb_q;
	logic [35:0] dark_lab_q;
	logic [7:0]  red, green, blue;
	logic [10:0] lab_l;
	logic [11:0] lab_a, lab_b;
	logic [9:0]  sum;
	logic        darker;
	logic [23:0] px_rgb;
	logic [35:0] px_lab;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	assign red    = s_tdata[7:0];
	assign green  = s_tdata[15:8];
	assign blue   = s_tdata[23:16];
	assign lab_l  = s_tdata[34:24];
	assign lab_a  = s_tdata[46:35];
	assign lab_b  = s_tdata[58:47];
	assign sum    = 10'(red) + 10'(green) + 10'(blue);
	assign darker = sum < dark_sum_q;
	assign px_rgb = {red, green, blue};
	assign px_lab = {1'b0, lab_l, lab_a, lab_b};

	always_comb begin
		push_data.bin      = cube_bin(red, green, blue);
		push_data.red      = red;
		push_data.green    = green;
		push_data.blue     = blue;
		push_data.lab_l    = lab_l;
		push_data.lab_a    = $signed(lab_a);
		push_data.lab_b    = $signed(lab_b);
		push_data.last     = s_tlast;
		push_data.dark_rgb = darker ? px_rgb : dark_rgb_q;
		push_data.dark_lab = darker ? px_lab : dark_lab_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_sum_q <= DARK_INIT;
			dark_rgb_q <= '0;
			dark_lab_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				dark_sum_q <= DARK_INIT;
				dark_rgb_q <= '0;
				dark_lab_q <= '0;
			end else if (darker) begin
				dark_sum_q <= sum;
				dark_rgb_q <= px_rgb;
				dark_lab_q <= px_lab;
			end
		end
	end

endmodule

### rtl/cbm_fifo.sv
// Short pixel queue between intake and accumulation.
module cbm_fifo import cbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t push_data,
	output logic full,
	input  logic pop,
	output pix_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	pix_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = cnt_q == (PTR_W+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/cbm_div.sv
// Restoring divider, one quotient bit per cycle.
module cbm_div import cbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CMP_W  = DIV_W + QUO_W - 1;
	localparam int STEP_W = $clog2(QUO_W);

	logic [CMP_W-1:0]  rem_q, dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              ge;

	assign ge           = rem_q >= dsh_q;
	assign rsp.done     = busy_q && step_q == STEP_W'(QUO_W - 1);
	assign rsp.quotient = {quo_q[QUO_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= CMP_W'(req.dividend);
			dsh_q <= CMP_W'(req.divisor) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (rsp.done)
				busy_q <= 1'b0;
		end
	end

endmodule

### rtl/cbm_back.sv
// Bin accumulation store and per-bin mean emission.
module cbm_back import cbm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pix_t                   head,
	input  logic                   empty,
	output logic                   pop,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	output logic                   m_tlast,
	input  logic                   m_tready,
	output div_req_t               div_req,
	input  div_rsp_t               div_rsp
);

	localparam int CNT_EXT_W = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;
	localparam logic [LAB_SUM_W-1:0] LAB_MAX = {1'b0, {(LAB_SUM_W-1){1'b1}}};
	localparam logic [LAB_SUM_W-1:0] LAB_MIN = {1'b1, {(LAB_SUM_W-1){1'b0}}};

	back_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0]   cnt_mem [CUBE_BINS];
	logic [3*RGB_SUM_W-1:0]   rgb_mem [CUBE_BINS];
	logic [3*LAB_SUM_W-1:0]   lab_mem [CUBE_BINS];
	logic [CUBE_BINS-1:0]     valid_q;

	logic [BIN_W-1:0]         rd_addr;
	logic [COUNT_WIDTH-1:0]   rd_cnt_q;
	logic [3*RGB_SUM_W-1:0]   rd_rgb_q;
	logic [3*LAB_SUM_W-1:0]   rd_lab_q;
	logic                     rd_valid_q;

	logic [COUNT_WIDTH-1:0]   cur_cnt;
	logic [RGB_SUM_W-1:0]     cur_rgb [3];
	logic [LAB_SUM_W-1:0]     cur_lab [3];
	logic [7:0]               px_rgb [3];
	logic [11:0]              px_lab [3];
	logic [RGB_SUM_W-1:0]     new_rgb [3];
	logic [LAB_SUM_W-1:0]     new_lab [3];
	logic [RGB_SUM_W:0]       rgb_add [3];
	logic [LAB_SUM_W:0]       lab_add [3];
	logic                     can_add;
	logic                     wr_en;

	pix_t                     pix_q;
	logic [BIN_W-1:0]         emit_bin_q;
	comp_t                    comp_q;
	logic [COUNT_WIDTH-1:0]   e_cnt_q;
	logic [RGB_SUM_W-1:0]     e_rgb_q [3];
	logic [LAB_SUM_W-1:0]     e_lab_q [3];
	logic [15:0]              mean_rgb_q [3];
	logic [10:0]              mean_l_q;
	logic [11:0]              mean_a_q, mean_b_q;
	logic [LAB_SUM_W-1:0]     lab_mag;
	logic [CNT_EXT_W-1:0]     cnt_ext;
	logic [COUNT_OUT_W-1:0]   cnt_out;

	logic                     out_load;
	logic                     emit_last;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic                     m_tvalid_q, m_tlast_q;

	assign rd_addr   = (state_q == BK_IDLE) ? head.bin : emit_bin_q;
	assign emit_last = emit_bin_q == BIN_W'(CUBE_BINS - 1);
	assign out_load  = state_q == BK_OUT && (!m_tvalid_q || m_tready);

	always_comb begin
		cur_cnt   = rd_valid_q ? rd_cnt_q : '0;
		px_rgb[0] = pix_q.red;
		px_rgb[1] = pix_q.green;
		px_rgb[2] = pix_q.blue;
		px_lab[0] = {1'b0, pix_q.lab_l};
		px_lab[1] = pix_q.lab_a;
		px_lab[2] = pix_q.lab_b;
		for (int k = 0; k < 3; k++) begin
			cur_rgb[k] = rd_valid_q ? rd_rgb_q[k*RGB_SUM_W +: RGB_SUM_W] : '0;
			cur_lab[k] = rd_valid_q ? rd_lab_q[k*LAB_SUM_W +: LAB_SUM_W] : '0;
			rgb_add[k] = {1'b0, cur_rgb[k]} + (RGB_SUM_W+1)'(px_rgb[k]);
			new_rgb[k] = rgb_add[k][RGB_SUM_W] ? '1 : rgb_add[k][RGB_SUM_W-1:0];
			lab_add[k] = {cur_lab[k][LAB_SUM_W-1], cur_lab[k]}
				+ (LAB_SUM_W+1)'($signed(px_lab[k]));
			if (lab_add[k][LAB_SUM_W] != lab_add[k][LAB_SUM_W-1])
				new_lab[k] = lab_add[k][LAB_SUM_W] ? LAB_MIN : LAB_MAX;
			else
				new_lab[k] = lab_add[k][LAB_SUM_W-1:0];
		end
		can_add = cur_cnt != '1;
		wr_en   = state_q == BK_UPD && can_add;
	end

	always_ff @(posedge clk) begin
		rd_cnt_q <= cnt_mem[rd_addr];
		rd_rgb_q <= rgb_mem[rd_addr];
		rd_lab_q <= lab_mem[rd_addr];
		if (wr_en) begin
			cnt_mem[pix_q.bin] <= cur_cnt + 1'b1;
			rgb_mem[pix_q.bin] <= {new_rgb[2], new_rgb[1], new_rgb[0]};
			lab_mem[pix_q.bin] <= {new_lab[2], new_lab[1], new_lab[0]};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:     if (!empty) state_d = BK_UPD;
			BK_UPD:      state_d = pix_q.last ? BK_EMIT_RD : BK_IDLE;
			BK_EMIT_RD:  state_d = BK_EMIT_LD;
			BK_EMIT_LD:  state_d = (cur_cnt == '0) ? BK_OUT : BK_DIV_GO;
			BK_DIV_GO:   state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: if (div_rsp.done) state_d = (comp_q == CMP_B) ? BK_OUT : BK_DIV_GO;
			BK_OUT:      if (out_load) state_d = emit_last ? BK_IDLE : BK_EMIT_RD;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		lab_mag = '0;
		div_req.start    = state_q == BK_DIV_GO;
		div_req.dividend = '0;
		div_req.divisor  = DIV_W'(e_cnt_q);
		pop              = state_q == BK_IDLE && !empty;
		unique case (comp_q)
			CMP_RED:   div_req.dividend = {e_rgb_q[0], 8'h00};
			CMP_GREEN: div_req.dividend = {e_rgb_q[1], 8'h00};
			CMP_BLUE:  div_req.dividend = {e_rgb_q[2], 8'h00};
			CMP_L:     lab_mag = e_lab_q[0];
			CMP_A:     lab_mag = e_lab_q[1][LAB_SUM_W-1] ? -e_lab_q[1] : e_lab_q[1];
			CMP_B:     lab_mag = e_lab_q[2][LAB_SUM_W-1] ? -e_lab_q[2] : e_lab_q[2];
			default:   lab_mag = '0;
		endcase
		if (comp_q == CMP_L || comp_q == CMP_A || comp_q == CMP_B)
			div_req.dividend = DVD_W'(lab_mag);
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && !empty)
			pix_q <= head;
		if (state_q == BK_EMIT_LD) begin
			e_cnt_q  <= cur_cnt;
			e_rgb_q  <= cur_rgb;
			e_lab_q  <= cur_lab;
			mean_rgb_q[0] <= '0;
			mean_rgb_q[1] <= '0;
			mean_rgb_q[2] <= '0;
			mean_l_q <= '0;
			mean_a_q <= '0;
			mean_b_q <= '0;
		end
		if (state_q == BK_DIV_WAIT && div_rsp.done) begin
			unique case (comp_q)
				CMP_RED:   mean_rgb_q[0] <= div_rsp.quotient[15:0];
				CMP_GREEN: mean_rgb_q[1] <= div_rsp.quotient[15:0];
				CMP_BLUE:  mean_rgb_q[2] <= div_rsp.quotient[15:0];
				CMP_L:     mean_l_q <= div_rsp.quotient[10:0];
				CMP_A:     mean_a_q <= e_lab_q[1][LAB_SUM_W-1] ?
					-div_rsp.quotient[11:0] : div_rsp.quotient[11:0];
				CMP_B:     mean_b_q <= e_lab_q[2][LAB_SUM_W-1] ?
					-div_rsp.quotient[11:0] : div_rsp.quotient[11:0];
				default:   mean_l_q <= mean_l_q;
			endcase
		end
	end

	assign cnt_ext = CNT_EXT_W'(e_cnt_q);
	assign cnt_out = (cnt_ext > CNT_EXT_W'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
		: cnt_ext[COUNT_OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= {5'b0, pix_q.dark_lab, pix_q.dark_rgb, mean_b_q, mean_a_q, mean_l_q,
				mean_rgb_q[2], mean_rgb_q[1], mean_rgb_q[0], cnt_out, emit_bin_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			emit_bin_q <= '0;
			comp_q     <= CMP_RED;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= valid_q[rd_addr];
			if (wr_en)
				valid_q[pix_q.bin] <= 1'b1;
			if (state_q == BK_UPD)
				emit_bin_q <= '0;
			if (state_q == BK_EMIT_LD)
				comp_q <= CMP_RED;
			if (state_q == BK_DIV_WAIT && div_rsp.done && comp_q != CMP_B)
				comp_q <= comp_t'(comp_q + 1'b1);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tlast_q  <= emit_last;
				emit_bin_q <= emit_bin_q + 1'b1;
				if (emit_last)
					valid_q <= '0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> m_tdata_q[BIN_W-1:0] == BIN_W'(CUBE_BINS - 1))
		else $error("last result not on final bin");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == BK_DIV_WAIT)
		else $error("divider finished outside wait state");

	a_store_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last) |=> valid_q == '0)
		else $error("store not cleared after frame");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == BK_IDLE)
		else $error("queue popped while busy");

endmodule
